### hw/rtl/mrp_pkg.sv
`timescale 1ns / 1ps

package mrp_pkg;

    localparam int ELAPSED_W  = 48;
    localparam int SEND_W     = 49;
    localparam int LEN_W      = 31;
    localparam int RATE_W     = 30;
    localparam int DUR_W      = 48;
    localparam int TOTAL_W    = 31;
    localparam int MODE_W     = 2;
    localparam int NS_W       = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
    localparam logic [SEND_W-1:0] SENT_MAX   = '1;

    localparam logic OP_START = 1'b0;

    localparam logic [MODE_W-1:0] MODE_TIMED   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COUNTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELAY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PACE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_RATE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_TOTAL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MSG_BYTES    = 3'd4;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_PACE  = 2'd1,
        KIND_DELAY = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic                 op;
        logic [ELAPSED_W-1:0] elapsed_ns;
    } in_word_t;

    typedef struct packed {
        logic [SEND_W-1:0] send_now;
        logic [LEN_W-1:0]  send_length;
        logic              run_done;
    } out_word_t;

    typedef struct packed {
        item_kind_t kind;
        logic       counted;
        logic       ge_dur;
    } front_ctl_t;

    typedef struct packed {
        item_kind_t        kind;
        logic              counted;
        logic              end_hit;
        logic [SEND_W-1:0] target;
    } queue_entry_t;

endpackage

### hw/rtl/message_rate_pacer_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Word
// s_*      in         s_valid / s_ready    mrp_pkg::in_word_t  (op, elapsed_ns)
// m_*      out        m_valid / m_ready    mrp_pkg::out_word_t (send_now, send_length, run_done)
// cfg_*    in         cfg_wr_en            cfg_index, cfg_data
//
// Sustained rate is one word per clock while m_ready stays high; an accepted word passes
// through nine arithmetic stages, the queue write and the output register.
// s_ready drops once QUEUE_DEPTH words are between the input and the queue head, so the
// queue depth must exceed the depth of the arithmetic pipeline to keep one word per clock.
// Reset is synchronous; the run stays ended (run_done high) until a start word arrives.
// A stall on m_ready fills the queue first and then holds off the input.

module message_rate_pacer_top #(
    parameter int TIME_BITS   = 48,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mrp_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mrp_pkg::out_word_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [mrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [mrp_pkg::MODE_W-1:0]  pace_mode_reg;
    logic [mrp_pkg::RATE_W-1:0]  msgs_per_second_reg;
    logic [mrp_pkg::DUR_W-1:0]   run_duration_ns_reg;
    logic [mrp_pkg::TOTAL_W-1:0] message_total_reg;
    logic [mrp_pkg::LEN_W-1:0]   message_bytes_reg;

    logic                  push;
    logic                  pop;
    logic                  entry_valid;
    mrp_pkg::queue_entry_t push_entry;
    mrp_pkg::queue_entry_t head_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pace_mode_reg       <= '0;
            msgs_per_second_reg <= '0;
            run_duration_ns_reg <= '0;
            message_total_reg   <= '0;
            message_bytes_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mrp_pkg::REG_PACE_MODE:    pace_mode_reg <= cfg_data[mrp_pkg::MODE_W-1:0];
                mrp_pkg::REG_MSG_RATE:     msgs_per_second_reg <= cfg_data[mrp_pkg::RATE_W-1:0];
                mrp_pkg::REG_RUN_DURATION: run_duration_ns_reg <= cfg_data[mrp_pkg::DUR_W-1:0];
                mrp_pkg::REG_MSG_TOTAL:    message_total_reg <= cfg_data[mrp_pkg::TOTAL_W-1:0];
                mrp_pkg::REG_MSG_BYTES:    message_bytes_reg <= cfg_data[mrp_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mrp_front #(
        .TIME_BITS  (TIME_BITS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .pace_mode      (pace_mode_reg),
        .msgs_per_second(msgs_per_second_reg),
        .run_duration_ns(run_duration_ns_reg),
        .message_total  (message_total_reg),
        .pop            (pop),
        .push           (push),
        .push_entry     (push_entry)
    );

    mrp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .not_empty (entry_valid),
        .head_entry(head_entry)
    );

    mrp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .entry_valid  (entry_valid),
        .entry        (head_entry),
        .pop          (pop),
        .message_total(message_total_reg),
        .message_bytes(message_bytes_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

### hw/rtl/mrp_front.sv
`timescale 1ns / 1ps

module mrp_front #(
    parameter int TIME_BITS   = 48,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mrp_pkg::in_word_t                 s_data,
    input  logic [mrp_pkg::MODE_W-1:0]        pace_mode,
    input  logic [mrp_pkg::RATE_W-1:0]        msgs_per_second,
    input  logic [mrp_pkg::DUR_W-1:0]         run_duration_ns,
    input  logic [mrp_pkg::TOTAL_W-1:0]       message_total,
    input  logic                              pop,
    output logic                              push,
    output mrp_pkg::queue_entry_t             push_entry
);

    localparam int TW = (TIME_BITS < mrp_pkg::ELAPSED_W) ? TIME_BITS : mrp_pkg::ELAPSED_W;
    localparam int QW = TW - 29;
    localparam int NS_W = mrp_pkg::NS_W;
    localparam int RATE_W = mrp_pkg::RATE_W;
    localparam int SEND_W = mrp_pkg::SEND_W;
    localparam int RR_W = NS_W + RATE_W;
    localparam int WH_W = QW + RATE_W;
    localparam int RECIP_W = 31;
    localparam int PLO_W = 32 + RECIP_W;
    localparam int PHI_W = RR_W - 32 + RECIP_W;
    localparam int GS_W = PHI_W + 32;
    localparam int SUM_W = WH_W + 1;
    localparam int CMP_W = (SUM_W > SEND_W) ? SUM_W : SEND_W;
    localparam int STAGES = 9;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [64:0] TIME_SPAN = 65'd1 << TW;
    localparam logic [QW-1:0] RECIP_T = QW'(TIME_SPAN / 65'd1000000000);
    localparam logic [RECIP_W-1:0] RECIP_R = RECIP_W'((64'd1 << RR_W) / 64'd1000000000);

    logic [CW-1:0]         inflight_reg, inflight_next;
    logic                  accept;
    logic [STAGES-1:0]     valid_reg;
    mrp_pkg::front_ctl_t   ctl_reg [STAGES];
    mrp_pkg::front_ctl_t   ctl_in;

    logic [TW-1:0]         a_t_reg;
    logic [TW-1:0]         b_t_reg;
    logic [TW+QW-1:0]      b_prod_reg;
    logic [TW-1:0]         c_t_reg;
    logic [QW-1:0]         c_qest_reg;
    logic [QW+NS_W-1:0]    c_qm_reg;
    logic [QW-1:0]         d_q_reg;
    logic [NS_W-1:0]       d_r_reg;
    logic [WH_W-1:0]       e_whole_reg;
    logic [RR_W-1:0]       e_rr_reg;
    logic [WH_W-1:0]       f_whole_reg;
    logic [RR_W-1:0]       f_rr_reg;
    logic [PLO_W-1:0]      f_plo_reg;
    logic [PHI_W-1:0]      f_phi_reg;
    logic [WH_W-1:0]       g_whole_reg;
    logic [RR_W-1:0]       g_rr_reg;
    logic [RATE_W-1:0]     g_fest_reg;
    logic [WH_W-1:0]       h_whole_reg;
    logic [RR_W-1:0]       h_rr_reg;
    logic [RATE_W-1:0]     h_fest_reg;
    logic [RR_W-1:0]       h_fm_reg;
    logic [WH_W-1:0]       i_whole_reg;
    logic [RATE_W-1:0]     i_frac_reg;

    logic [QW-1:0]         q_est;
    logic [NS_W:0]         r_est;
    logic [NS_W+1:0]       r_chk;
    logic [GS_W-1:0]       g_sum;
    logic [NS_W:0]         f_rem;
    logic [NS_W+1:0]       f_chk;
    logic [CMP_W-1:0]      target_sum;
    logic [SEND_W-1:0]     target_sat;
    logic [SEND_W-1:0]     total_x;
    logic                  ge_total;

    assign accept  = s_valid && s_ready;
    assign s_ready = inflight_reg < CW'(QUEUE_DEPTH);

    // Credits cover the whole arithmetic pipeline and the queue, so a word that
    // enters here always finds a free queue slot when it arrives there.
    always_comb begin
        inflight_next = inflight_reg;
        if (accept && !pop) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (!accept && pop) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_comb begin
        ctl_in.counted = (pace_mode == mrp_pkg::MODE_COUNTED);
        ctl_in.ge_dur  = s_data.elapsed_ns[TW-1:0] >= run_duration_ns[TW-1:0];
        if (s_data.op == mrp_pkg::OP_START) begin
            ctl_in.kind = mrp_pkg::KIND_START;
        end else begin
            unique case (pace_mode) inside
                mrp_pkg::MODE_TIMED, mrp_pkg::MODE_COUNTED: ctl_in.kind = mrp_pkg::KIND_PACE;
                mrp_pkg::MODE_DELAY: ctl_in.kind = mrp_pkg::KIND_DELAY;
                default: ctl_in.kind = mrp_pkg::KIND_DELAY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
            valid_reg    <= '0;
        end else begin
            inflight_reg <= inflight_next;
            valid_reg    <= {valid_reg[STAGES-2:0], accept};
        end
    end

    always_ff @(posedge aclk) begin
        ctl_reg[0] <= ctl_in;
        for (int i = 1; i < STAGES; i++) begin
            ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    // Quotient and remainder of the time by one second. The reciprocal estimate
    // is at most one low, fixed by a single compare and subtract.
    assign q_est = b_prod_reg[TW+QW-1:TW];
    assign r_est = c_t_reg[NS_W:0] - c_qm_reg[NS_W:0];
    assign r_chk = {1'b0, r_est} - (NS_W+2)'(mrp_pkg::NS_PER_SEC);

    // The fractional part of the product goes the same way with a 60-bit
    // dividend, whose reciprocal product is split into two partial products.
    assign g_sum = {f_phi_reg, 32'd0} + GS_W'(f_plo_reg);
    assign f_rem = h_rr_reg[NS_W:0] - h_fm_reg[NS_W:0];
    assign f_chk = {1'b0, f_rem} - (NS_W+2)'(mrp_pkg::NS_PER_SEC);

    always_ff @(posedge aclk) begin
        a_t_reg     <= s_data.elapsed_ns[TW-1:0];

        b_t_reg     <= a_t_reg;
        b_prod_reg  <= (TW+QW)'(a_t_reg) * (TW+QW)'(RECIP_T);

        c_t_reg     <= b_t_reg;
        c_qest_reg  <= q_est;
        c_qm_reg    <= (QW+NS_W)'(q_est) * (QW+NS_W)'(mrp_pkg::NS_PER_SEC);

        if (!r_chk[NS_W+1]) begin
            d_q_reg <= c_qest_reg + 1'b1;
            d_r_reg <= r_chk[NS_W-1:0];
        end else begin
            d_q_reg <= c_qest_reg;
            d_r_reg <= r_est[NS_W-1:0];
        end

        e_whole_reg <= WH_W'(d_q_reg) * WH_W'(msgs_per_second);
        e_rr_reg    <= RR_W'(d_r_reg) * RR_W'(msgs_per_second);

        f_whole_reg <= e_whole_reg;
        f_rr_reg    <= e_rr_reg;
        f_plo_reg   <= PLO_W'(e_rr_reg[31:0]) * PLO_W'(RECIP_R);
        f_phi_reg   <= PHI_W'(e_rr_reg[RR_W-1:32]) * PHI_W'(RECIP_R);

        g_whole_reg <= f_whole_reg;
        g_rr_reg    <= f_rr_reg;
        g_fest_reg  <= g_sum[RR_W+RATE_W-1:RR_W];

        h_whole_reg <= g_whole_reg;
        h_rr_reg    <= g_rr_reg;
        h_fest_reg  <= g_fest_reg;
        h_fm_reg    <= RR_W'(g_fest_reg) * RR_W'(mrp_pkg::NS_PER_SEC);

        i_whole_reg <= h_whole_reg;
        i_frac_reg  <= f_chk[NS_W+1] ? h_fest_reg : h_fest_reg + 1'b1;
    end

    always_comb begin
        target_sum = CMP_W'(i_whole_reg) + CMP_W'(i_frac_reg) + CMP_W'(1);
        if (target_sum > CMP_W'(mrp_pkg::SENT_MAX)) begin
            target_sat = mrp_pkg::SENT_MAX;
        end else begin
            target_sat = target_sum[SEND_W-1:0];
        end
        total_x  = SEND_W'(message_total);
        ge_total = target_sat >= total_x;

        push               = valid_reg[STAGES-1];
        push_entry.kind    = ctl_reg[STAGES-1].kind;
        push_entry.counted = ctl_reg[STAGES-1].counted;
        push_entry.end_hit = ctl_reg[STAGES-1].counted ? ge_total : ctl_reg[STAGES-1].ge_dur;
        if (ctl_reg[STAGES-1].counted && !ge_total) begin
            push_entry.target = target_sat;
        end else if (ctl_reg[STAGES-1].counted) begin
            push_entry.target = total_x;
        end else begin
            push_entry.target = target_sat;
        end
    end

    a_credit_held: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> inflight_reg != '0)
        else $error("Word reached the queue without a credit outstanding.");

endmodule

### hw/rtl/mrp_queue.sv
`timescale 1ns / 1ps

module mrp_queue #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mrp_pkg::queue_entry_t push_entry,
    input  logic                  pop,
    output logic                  not_empty,
    output mrp_pkg::queue_entry_t head_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrp_pkg::queue_entry_t entries_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty  = count_reg != '0;
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> count_reg != CNT_W'(DEPTH))
        else $error("Queue written while full.");

endmodule

### hw/rtl/mrp_back.sv
`timescale 1ns / 1ps

module mrp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        entry_valid,
    input  mrp_pkg::queue_entry_t       entry,
    output logic                        pop,
    input  logic [mrp_pkg::TOTAL_W-1:0] message_total,
    input  logic [mrp_pkg::LEN_W-1:0]   message_bytes,
    output logic                        m_valid,
    input  logic                        m_ready,
    output mrp_pkg::out_word_t          m_data
);

    localparam int SEND_W = mrp_pkg::SEND_W;

    logic [SEND_W-1:0]   sent_reg, sent_next;
    logic                finished_reg, finished_next;
    logic                out_valid_reg, out_valid_next;
    mrp_pkg::out_word_t  out_data_reg, out_data_next;
    logic                take;
    logic [SEND_W:0]     diff;
    logic                fin;

    assign take    = entry_valid && (!out_valid_reg || m_ready);
    assign pop     = take;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign diff = {1'b0, entry.target} - {1'b0, sent_reg};

    always_comb begin
        sent_next      = sent_reg;
        finished_next  = finished_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        fin            = entry.end_hit
                         || (entry.counted && sent_reg >= SEND_W'(message_total));
        if (take) begin
            out_valid_next            = 1'b1;
            out_data_next.send_now    = '0;
            out_data_next.send_length = message_bytes;
            out_data_next.run_done    = finished_reg;
            unique case (entry.kind)
                mrp_pkg::KIND_START: begin
                    sent_next              = '0;
                    finished_next          = 1'b0;
                    out_data_next.run_done = 1'b0;
                end
                mrp_pkg::KIND_PACE: begin
                    if (!finished_reg) begin
                        // A target behind the count sends nothing and keeps the count.
                        if (!diff[SEND_W]) begin
                            out_data_next.send_now = diff[SEND_W-1:0];
                            sent_next              = entry.target;
                        end
                        finished_next          = fin;
                        out_data_next.run_done = fin;
                    end
                end
                mrp_pkg::KIND_DELAY: begin
                    if (!finished_reg) begin
                        finished_next          = fin;
                        out_data_next.run_done = fin;
                    end
                end
                default: begin
                    out_data_next.run_done = finished_reg;
                end
            endcase
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg      <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            sent_reg      <= sent_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    a_start_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        take && entry.kind == mrp_pkg::KIND_START |=> !finished_reg && sent_reg == '0)
        else $error("Start word did not arm the run.");

    a_idle_sends_nothing: assert property (@(posedge aclk) disable iff (!aresetn)
        take && finished_reg && entry.kind != mrp_pkg::KIND_START
        |=> m_valid && m_data.run_done && m_data.send_now == '0)
        else $error("Sample after the run ended produced sends.");

    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        take && entry.kind != mrp_pkg::KIND_START |=> sent_reg >= $past(sent_reg))
        else $error("Sent count went down without a start word.");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mrp_pkg::*;

    localparam logic               OP_SAMPLE   = 1'b1;
    localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [DUR_W-1:0]   DUR_MAX     = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
    localparam logic [LEN_W-1:0]   BYTES_MAX   = '1;
    localparam int                 DRAIN_LIMIT = 20000;
    localparam int                 SETTLE      = 12;

    class pacer_scoreboard;
        logic [MODE_W-1:0]  pace_mode;
        logic [RATE_W-1:0]  rate;
        logic [DUR_W-1:0]   duration;
        logic [TOTAL_W-1:0] total;
        logic [LEN_W-1:0]   msg_bytes;
        logic [SEND_W-1:0]  sent;
        bit                 run_over;
        out_word_t          pending_sends[$];
        int                 mismatches;
        int                 failures;

        function new();
            pace_mode  = MODE_TIMED;
            rate       = '0;
            duration   = '0;
            total      = '0;
            msg_bytes  = '0;
            sent       = '0;
            run_over   = 1'b1;
            mismatches = 0;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PACE_MODE:    pace_mode = val[MODE_W-1:0];
                REG_MSG_RATE:     rate      = val[RATE_W-1:0];
                REG_RUN_DURATION: duration  = val[DUR_W-1:0];
                REG_MSG_TOTAL:    total     = val[TOTAL_W-1:0];
                REG_MSG_BYTES:    msg_bytes = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(t * rate / 1e9) + 1, formed at full width and saturated.
        function logic [SEND_W-1:0] catch_up_target(logic [ELAPSED_W-1:0] t);
            logic [79:0] prod;
            logic [79:0] whole;
            prod  = {32'd0, t} * {50'd0, rate};
            whole = prod / {50'd0, NS_PER_SEC};
            if (whole >= {31'd0, SENT_MAX})
                return SENT_MAX;
            return whole[SEND_W-1:0] + 1'b1;
        endfunction

        function void note_word(in_word_t w);
            logic [SEND_W-1:0] tgt;
            out_word_t         res;
            res.send_now = '0;
            if (w.op == OP_START) begin
                sent     = '0;
                run_over = 1'b0;
            end else if (!run_over) begin
                if (pace_mode == MODE_TIMED || pace_mode == MODE_COUNTED) begin
                    tgt = catch_up_target(w.elapsed_ns);
                    if (pace_mode == MODE_COUNTED && tgt > {18'd0, total})
                        tgt = {18'd0, total};
                    if (tgt > sent) begin
                        res.send_now = tgt - sent;
                        sent         = tgt;
                    end
                end
                if (pace_mode == MODE_COUNTED) begin
                    if (sent >= {18'd0, total})
                        run_over = 1'b1;
                end else if (w.elapsed_ns >= duration) begin
                    run_over = 1'b1;
                end
            end
            res.send_length = msg_bytes;
            res.run_done    = run_over;
            pending_sends.push_back(res);
        endfunction

        function void report(string what, out_word_t want, out_word_t got);
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch (%s): send_now %0d/%0d len %0d/%0d done %0d/%0d",
                         $time, what, want.send_now, got.send_now, want.send_length,
                         got.send_length, want.run_done, got.run_done);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            if (pending_sends.size() == 0) begin
                want = '0;
                report("unexpected word", want, got);
                return;
            end
            want = pending_sends.pop_front();
            if (got.send_now !== want.send_now || got.send_length !== want.send_length ||
                got.run_done !== want.run_done)
                report("field", want, got);
        endfunction

        function int pending();
            return pending_sends.size();
        endfunction

        function void close_out();
            failures += pending_sends.size();
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_word_t           s_data;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_word_t          m_data;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pacer_scoreboard sb = new();

    int burst_left = 0;
    int ready_left = 0;
    bit ready_level = 1'b1;

    message_rate_pacer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // The receiver alternates ready stretches with short and long stalls; the long ones
    // fill the result queue and push back on the input.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 5))
                0: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(20, 45);
                end
                1, 2: begin
                    ready_level = 1'b0;
                    ready_left  = $urandom_range(1, 4);
                end
                default: begin
                    ready_level = 1'b1;
                    ready_left  = $urandom_range(1, 40);
                end
            endcase
        end else begin
            ready_left--;
        end
        m_ready <= ready_level;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_data);
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [ELAPSED_W-1:0] rand48();
        return ELAPSED_W'({$urandom, $urandom});
    endfunction

    function automatic logic [ELAPSED_W-1:0] mask48(int w);
        return (w >= ELAPSED_W) ? ELAPSED_MAX : ((48'h1 << w) - 48'h1);
    endfunction

    function automatic logic [ELAPSED_W-1:0] sat_add(logic [ELAPSED_W-1:0] a,
                                                     logic [ELAPSED_W-1:0] b);
        logic [ELAPSED_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
    endfunction

    task automatic send_word(input logic op, input logic [ELAPSED_W-1:0] t);
        int gap;
        @(negedge aclk);
        s_valid         = 1'b1;
        s_data.op       = op;
        s_data.elapsed_ns = t;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(s_data);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic load_config(input logic [MODE_W-1:0] mode, input logic [RATE_W-1:0] r,
                               input logic [DUR_W-1:0] d, input logic [TOTAL_W-1:0] tot,
                               input logic [LEN_W-1:0] b);
        drain_results();
        write_reg(REG_PACE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_MSG_RATE, CFG_DATA_W'(r));
        write_reg(REG_RUN_DURATION, CFG_DATA_W'(d));
        write_reg(REG_MSG_TOTAL, CFG_DATA_W'(tot));
        write_reg(REG_MSG_BYTES, CFG_DATA_W'(b));
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_phase(input int quota);
        logic [MODE_W-1:0]    mode;
        logic [31:0]          r;
        logic [DUR_W-1:0]     d;
        logic [TOTAL_W-1:0]   tot;
        logic [ELAPSED_W-1:0] step_mask;
        logic [ELAPSED_W-1:0] t;
        logic [ELAPSED_W-1:0] step;
        int                   e;
        int                   n;
        int                   len;
        int                   sel;
        int                   burst;

        sel = $urandom_range(0, 9);
        mode = (sel < 4) ? MODE_TIMED : (sel < 8) ? MODE_COUNTED :
               (sel == 8) ? MODE_DELAY : MODE_UNUSED;
        e = $urandom_range(0, 30);
        r = $urandom & ((e == 32) ? 32'hFFFFFFFF : ((32'h1 << e) - 32'h1));
        if (r > NS_PER_SEC || $urandom_range(0, 7) == 0)
            r = 32'(NS_PER_SEC);
        e = $urandom_range(4, ELAPSED_W);
        step_mask = mask48(e - 3);
        d = rand48() & mask48(e);
        tot = ($urandom_range(0, 5) == 0) ? TOTAL_W'($urandom) : TOTAL_W'($urandom_range(0, 80));
        load_config(mode, r[RATE_W-1:0], d, tot, LEN_W'($urandom));

        n = 0;
        while (n < quota) begin
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
                // Well-formed run: a start word, then mostly nondecreasing time samples.
                send_word(OP_START, rand48());
                n++;
                t = ($urandom_range(0, 3) == 0) ? '0 : (rand48() & step_mask);
                len = $urandom_range(2, 16);
                repeat (len) begin
                    case ($urandom_range(0, 19))
                        0: begin
                            step = rand48() & step_mask;
                            t = (t > step) ? t - step : '0;
                        end
                        1: begin
                            send_word(OP_START, rand48());
                            n++;
                            t = '0;
                        end
                        default: t = sat_add(t, rand48() & step_mask);
                    endcase
                    send_word(OP_SAMPLE, t);
                    n++;
                end
            end else if (sel == 8) begin
                send_word(logic'($urandom_range(0, 1)), rand48());
                n++;
            end else begin
                burst = $urandom_range(1, 3);
                repeat (burst) send_word(OP_SAMPLE, rand48());
                n += burst;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // A sample before any start finds the pacer idle.
        send_word(OP_SAMPLE, '0);

        // Zero duration still sends one message at elapsed zero.
        load_config(MODE_TIMED, NS_PER_SEC, '0, '0, BYTES_MAX);
        send_word(OP_START, ELAPSED_MAX);
        send_word(OP_SAMPLE, '0);

        // Time going backwards, a restart during the run, and the largest elapsed value.
        load_config(MODE_TIMED, NS_PER_SEC, DUR_MAX, TOTAL_MAX, '0);
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, 48'd1000);
        send_word(OP_SAMPLE, 48'd500);
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, 48'd100);
        send_word(OP_SAMPLE, ELAPSED_MAX);

        // Counted mode with nothing to send finishes on the first sample.
        load_config(MODE_COUNTED, 30'd5, '0, '0, LEN_W'(12345));
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, '0);

        load_config(MODE_COUNTED, NS_PER_SEC, DUR_MAX, TOTAL_W'(3), LEN_W'(64));
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, '0);
        send_word(OP_SAMPLE, 48'd1);
        send_word(OP_SAMPLE, 48'd10);

        load_config(MODE_COUNTED, NS_PER_SEC, '0, TOTAL_MAX, BYTES_MAX);
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, ELAPSED_MAX);

        load_config(MODE_DELAY, NS_PER_SEC, DUR_W'(50), TOTAL_W'(7), LEN_W'(1));
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, 48'd10);
        send_word(OP_SAMPLE, 48'd50);

        // The unused mode code paces like delay mode.
        load_config(MODE_UNUSED, NS_PER_SEC, DUR_W'(20), TOTAL_W'(7), LEN_W'(2));
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, 48'd30);

        // A zero rate keeps the target at one.
        load_config(MODE_TIMED, '0, DUR_W'(100), TOTAL_W'(7), LEN_W'(3));
        send_word(OP_START, '0);
        send_word(OP_SAMPLE, 48'd200);

        repeat (9) random_phase(68);

        drain_results();
        sb.close_out();
        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
